// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the refresh-rate fallback policy RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RRFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrfp assertion failed");

// Next-cycle implication, disabled during reset.
`define RRFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrfp assertion failed");

`endif

// ----- rtl/core/rrfp_pkg.sv -----
// Package for the refresh-rate fallback policy: widths, codes, constants, types.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps

package rrfp_pkg;

    localparam int GEN_BITS     = 32;
    localparam int MILLIHZ_BITS = 20;
    localparam int TIME_BITS    = 63;
    localparam int HZ_BITS      = 11;
    localparam int TARGET_BITS  = 7;

    localparam logic [TIME_BITS-1:0] TTL_NS = TIME_BITS'(64'd2000000000);

    // Round-to-nearest Hz: floor((mhz + 500) * ceil(2^31 / 1000) / 2^31).
    localparam int ROUND_BITS  = MILLIHZ_BITS + 1;
    localparam int RECIP_SHIFT = 31;
    localparam int RECIP_BITS  = 22;
    localparam int PROD_BITS   = ROUND_BITS + RECIP_BITS;
    localparam logic [RECIP_BITS-1:0] RECIP_1000 = RECIP_BITS'(2147484);
    localparam logic [MILLIHZ_BITS-1:0] HALF_HZ_MHZ = MILLIHZ_BITS'(500);

    localparam logic [HZ_BITS-1:0] FALLBACK_HZ = HZ_BITS'(60);
    localparam logic [HZ_BITS-1:0] MOTION_HZ   = HZ_BITS'(120);

    // Tolerance windows: target * 1000 +/- 1000 millihertz.
    localparam logic [MILLIHZ_BITS-1:0] WIN60_LO  = MILLIHZ_BITS'(59000);
    localparam logic [MILLIHZ_BITS-1:0] WIN60_HI  = MILLIHZ_BITS'(61000);
    localparam logic [MILLIHZ_BITS-1:0] WIN90_LO  = MILLIHZ_BITS'(89000);
    localparam logic [MILLIHZ_BITS-1:0] WIN90_HI  = MILLIHZ_BITS'(91000);
    localparam logic [MILLIHZ_BITS-1:0] WIN120_LO = MILLIHZ_BITS'(119000);
    localparam logic [MILLIHZ_BITS-1:0] WIN120_HI = MILLIHZ_BITS'(121000);

    typedef enum logic [2:0] {
        OP_BEGIN   = 3'd0,
        OP_END     = 3'd1,
        OP_RECORD  = 3'd2,
        OP_OBSERVE = 3'd3,
        OP_PROTECT = 3'd4,
        OP_QUERY   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        CFG_RATE_POLICY    = 2'd0,
        CFG_TEMPORAL_MODE  = 2'd1,
        CFG_ADAPTIVE_GUARD = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        POLICY_MIN   = 3'd1,
        POLICY_60HZ  = 3'd3,
        POLICY_90HZ  = 3'd4,
        POLICY_120HZ = 3'd5
    } policy_t;

    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd1,
        MODE_MOTION = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        FB_NONE        = 3'd0,
        FB_NO_SURFACE  = 3'd1,
        FB_GUARD_INVAL = 3'd2,
        FB_THERMAL     = 3'd3,
        FB_BATTERY     = 3'd4,
        FB_NOT_APPLIED = 3'd5,
        FB_STALE       = 3'd6,
        FB_REJECTED    = 3'd7
    } fb_code_t;

    typedef struct packed {
        logic [2:0]              opcode;
        logic [GEN_BITS-1:0]     generation;
        logic                    accepted;
        logic [MILLIHZ_BITS-1:0] measured_millihz;
        logic [TIME_BITS-1:0]    time_ns;
        logic                    thermal_flag;
        logic                    battery_flag;
        logic                    guard_valid;
    } item_t;

    typedef struct packed {
        logic                    surface_on;
        logic                    request_flag;
        logic [GEN_BITS-1:0]     surface_tag;
        logic [GEN_BITS-1:0]     request_tag;
        logic [MILLIHZ_BITS-1:0] seen_millihz;
        logic [HZ_BITS-1:0]      seen_hz;
        logic [TIME_BITS-1:0]    seen_time;
        logic                    thermal_on;
        logic                    battery_low;
        logic                    guard_ok;
        logic [2:0]              rate_policy;
        logic [1:0]              temporal_mode;
        logic                    adaptive_guard;
    } view_t;

    typedef struct packed {
        logic                    ready_res;
        logic                    request_ok;
        logic [GEN_BITS-1:0]     current_generation;
        logic [GEN_BITS-1:0]     accepted_generation;
        logic [TARGET_BITS-1:0]  target_hz;
        logic [MILLIHZ_BITS-1:0] last_millihz;
        logic [TIME_BITS-1:0]    last_seen_ns;
        logic                    fresh;
        logic [HZ_BITS-1:0]      effective_hz;
        logic [2:0]              fallback_code;
        logic                    motion_ok;
    } result_t;

    function automatic logic [TARGET_BITS-1:0] policy_hz(input logic [2:0] p);
        logic [TARGET_BITS-1:0] hz;
        case (p)
            POLICY_60HZ:  hz = TARGET_BITS'(60);
            POLICY_90HZ:  hz = TARGET_BITS'(90);
            POLICY_120HZ: hz = TARGET_BITS'(120);
            default:      hz = '0;
        endcase
        return hz;
    endfunction

endpackage

// ----- rtl/core/refresh_rate_fallback_policy.sv -----
// Top level of the refresh-rate fallback policy: input register, state, result register.
// Depends on rrfp_pkg, rrfp_state, rrfp_eval and assert_macros.svh.
//
// One event is accepted per clock while in_stall is low. Each event passes through an input
// register and is applied to the policy state as it leaves that register; a query's status
// item is written to the result register on that same edge.
// in_stall rises only while a query waits in the input register behind a result that
// the downstream side is stalling. Configuration writes are taken in any cycle
// (cfg_ready is always high) and must be issued only while no event is in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module refresh_rate_fallback_policy
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [1:0]                           cfg_index,
    input  logic [2:0]                           cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [2:0]                           opcode,
    input  logic [rrfp_pkg::GEN_BITS-1:0]        generation,
    input  logic                                 accepted,
    input  logic [rrfp_pkg::MILLIHZ_BITS-1:0]    measured_millihz,
    input  logic [rrfp_pkg::TIME_BITS-1:0]       time_ns,
    input  logic                                 thermal_flag,
    input  logic                                 battery_flag,
    input  logic                                 guard_valid,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 ready_res,
    output logic                                 request_ok,
    output logic [rrfp_pkg::GEN_BITS-1:0]        current_generation,
    output logic [rrfp_pkg::GEN_BITS-1:0]        accepted_generation,
    output logic [rrfp_pkg::TARGET_BITS-1:0]     target_hz,
    output logic [rrfp_pkg::MILLIHZ_BITS-1:0]    last_millihz,
    output logic [rrfp_pkg::TIME_BITS-1:0]       last_seen_ns,
    output logic                                 fresh,
    output logic [rrfp_pkg::HZ_BITS-1:0]         effective_hz,
    output logic [2:0]                           fallback_code,
    output logic                                 motion_ok
);

    logic               s1_valid_reg, s1_valid_next;
    rrfp_pkg::item_t    s1_item_reg;
    logic               s1_query;
    logic               s1_adv;
    logic               in_take;
    logic               out_valid_reg, out_valid_next;
    rrfp_pkg::result_t  out_res_reg;
    rrfp_pkg::result_t  eval_res;
    rrfp_pkg::view_t    view;
    logic               cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // A query may leave the input register only once the result register is free.
    assign s1_query = (s1_item_reg.opcode == rrfp_pkg::OP_QUERY);
    assign s1_adv   = s1_valid_reg && (!s1_query || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        if (s1_adv && s1_query)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg.opcode           <= opcode;
            s1_item_reg.generation       <= generation;
            s1_item_reg.accepted         <= accepted;
            s1_item_reg.measured_millihz <= measured_millihz;
            s1_item_reg.time_ns          <= time_ns;
            s1_item_reg.thermal_flag     <= thermal_flag;
            s1_item_reg.battery_flag     <= battery_flag;
            s1_item_reg.guard_valid      <= guard_valid;
        end
        if (s1_adv && s1_query)
            out_res_reg <= eval_res;
    end

    rrfp_state u_state
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .upd_en    (s1_adv),
        .item      (s1_item_reg),
        .view      (view)
    );

    rrfp_eval u_eval
    (
        .now_ns (s1_item_reg.time_ns),
        .view   (view),
        .result (eval_res)
    );

    assign out_valid           = out_valid_reg;
    assign ready_res           = out_res_reg.ready_res;
    assign request_ok          = out_res_reg.request_ok;
    assign current_generation  = out_res_reg.current_generation;
    assign accepted_generation = out_res_reg.accepted_generation;
    assign target_hz           = out_res_reg.target_hz;
    assign last_millihz        = out_res_reg.last_millihz;
    assign last_seen_ns        = out_res_reg.last_seen_ns;
    assign fresh               = out_res_reg.fresh;
    assign effective_hz        = out_res_reg.effective_hz;
    assign fallback_code       = out_res_reg.fallback_code;
    assign motion_ok           = out_res_reg.motion_ok;

    `RRFP_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, s1_valid_reg && s1_query && out_valid_reg && out_stall)
    `RRFP_ASSERT_NXT(a_query_lands, clk, rst_n, s1_adv && s1_query, out_valid_reg)

endmodule

// ----- rtl/core/rrfp_state.sv -----
// Policy state and configuration registers of the refresh-rate fallback policy.
// Depends on rrfp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrfp_state
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [2:0]           cfg_data,
    input  logic                 upd_en,
    input  rrfp_pkg::item_t      item,
    output rrfp_pkg::view_t      view
);

    logic                                   surface_on_reg, surface_on_next;
    logic                                   request_flag_reg, request_flag_next;
    logic [rrfp_pkg::GEN_BITS-1:0]          surface_tag_reg, surface_tag_next;
    logic [rrfp_pkg::GEN_BITS-1:0]          request_tag_reg, request_tag_next;
    logic [rrfp_pkg::MILLIHZ_BITS-1:0]      seen_millihz_reg, seen_millihz_next;
    logic [rrfp_pkg::HZ_BITS-1:0]           seen_hz_reg, seen_hz_next;
    logic [rrfp_pkg::TIME_BITS-1:0]         seen_time_reg, seen_time_next;
    logic                                   thermal_on_reg, thermal_on_next;
    logic                                   battery_low_reg, battery_low_next;
    logic                                   guard_ok_reg, guard_ok_next;
    logic [2:0]                             rate_policy_reg, rate_policy_next;
    logic [1:0]                             temporal_mode_reg, temporal_mode_next;
    logic                                   adaptive_guard_reg, adaptive_guard_next;

    logic [rrfp_pkg::ROUND_BITS-1:0]        round_sum;
    logic [rrfp_pkg::PROD_BITS-1:0]         round_prod;
    logic [rrfp_pkg::HZ_BITS-1:0]           item_hz;
    logic                                   gen_match;

    // Rounded Hz of the incoming observation, held next to the raw millihertz.
    assign round_sum  = rrfp_pkg::ROUND_BITS'(item.measured_millihz)
                      + rrfp_pkg::ROUND_BITS'(rrfp_pkg::HALF_HZ_MHZ);
    assign round_prod = rrfp_pkg::PROD_BITS'(round_sum)
                      * rrfp_pkg::PROD_BITS'(rrfp_pkg::RECIP_1000);
    assign item_hz    = round_prod[rrfp_pkg::RECIP_SHIFT +: rrfp_pkg::HZ_BITS];
    assign gen_match  = (item.generation == surface_tag_reg);

    always_comb
    begin
        surface_on_next     = surface_on_reg;
        request_flag_next   = request_flag_reg;
        surface_tag_next    = surface_tag_reg;
        request_tag_next    = request_tag_reg;
        seen_millihz_next   = seen_millihz_reg;
        seen_hz_next        = seen_hz_reg;
        seen_time_next      = seen_time_reg;
        thermal_on_next     = thermal_on_reg;
        battery_low_next    = battery_low_reg;
        guard_ok_next       = guard_ok_reg;
        rate_policy_next    = rate_policy_reg;
        temporal_mode_next  = temporal_mode_reg;
        adaptive_guard_next = adaptive_guard_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                rrfp_pkg::CFG_RATE_POLICY:
                begin
                    if (cfg_data < rrfp_pkg::POLICY_MIN)
                        rate_policy_next = rrfp_pkg::POLICY_MIN;
                    else if (cfg_data > rrfp_pkg::POLICY_120HZ)
                        rate_policy_next = rrfp_pkg::POLICY_120HZ;
                    else
                        rate_policy_next = cfg_data;
                    request_tag_next  = '0;
                    request_flag_next = 1'b0;
                end
                rrfp_pkg::CFG_TEMPORAL_MODE:
                begin
                    if (cfg_data[1:0] < rrfp_pkg::MODE_PLAIN)
                        temporal_mode_next = rrfp_pkg::MODE_PLAIN;
                    else if (cfg_data[1:0] > rrfp_pkg::MODE_MOTION)
                        temporal_mode_next = rrfp_pkg::MODE_MOTION;
                    else
                        temporal_mode_next = cfg_data[1:0];
                    request_tag_next  = '0;
                    request_flag_next = 1'b0;
                end
                rrfp_pkg::CFG_ADAPTIVE_GUARD:
                begin
                    adaptive_guard_next = cfg_data[0];
                    request_tag_next    = '0;
                    request_flag_next   = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        else if (upd_en)
        begin
            unique case (item.opcode)
                rrfp_pkg::OP_BEGIN:
                begin
                    surface_tag_next  = item.generation;
                    request_tag_next  = '0;
                    seen_millihz_next = '0;
                    seen_hz_next      = '0;
                    seen_time_next    = '0;
                    surface_on_next   = (item.generation != '0);
                    request_flag_next = 1'b0;
                end
                rrfp_pkg::OP_END:
                begin
                    if (gen_match)
                    begin
                        surface_on_next   = 1'b0;
                        request_flag_next = 1'b0;
                        seen_millihz_next = '0;
                        seen_hz_next      = '0;
                        seen_time_next    = '0;
                    end
                end
                rrfp_pkg::OP_RECORD:
                begin
                    if (surface_on_reg && gen_match)
                    begin
                        request_tag_next  = item.generation;
                        request_flag_next = item.accepted;
                    end
                end
                rrfp_pkg::OP_OBSERVE:
                begin
                    if (surface_on_reg && gen_match && item.measured_millihz != '0
                        && item.time_ns != '0)
                    begin
                        seen_millihz_next = item.measured_millihz;
                        seen_hz_next      = item_hz;
                        seen_time_next    = item.time_ns;
                    end
                end
                rrfp_pkg::OP_PROTECT:
                begin
                    thermal_on_next  = item.thermal_flag;
                    battery_low_next = item.battery_flag;
                    guard_ok_next    = item.guard_valid;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            surface_on_reg     <= 1'b0;
            request_flag_reg   <= 1'b0;
            surface_tag_reg    <= '0;
            request_tag_reg    <= '0;
            seen_millihz_reg   <= '0;
            seen_hz_reg        <= '0;
            seen_time_reg      <= '0;
            thermal_on_reg     <= 1'b0;
            battery_low_reg    <= 1'b0;
            guard_ok_reg       <= 1'b0;
            rate_policy_reg    <= rrfp_pkg::POLICY_MIN;
            temporal_mode_reg  <= rrfp_pkg::MODE_PLAIN;
            adaptive_guard_reg <= 1'b0;
        end
        else
        begin
            surface_on_reg     <= surface_on_next;
            request_flag_reg   <= request_flag_next;
            surface_tag_reg    <= surface_tag_next;
            request_tag_reg    <= request_tag_next;
            seen_millihz_reg   <= seen_millihz_next;
            seen_hz_reg        <= seen_hz_next;
            seen_time_reg      <= seen_time_next;
            thermal_on_reg     <= thermal_on_next;
            battery_low_reg    <= battery_low_next;
            guard_ok_reg       <= guard_ok_next;
            rate_policy_reg    <= rate_policy_next;
            temporal_mode_reg  <= temporal_mode_next;
            adaptive_guard_reg <= adaptive_guard_next;
        end
    end

    always_comb
    begin
        view.surface_on     = surface_on_reg;
        view.request_flag   = request_flag_reg;
        view.surface_tag    = surface_tag_reg;
        view.request_tag    = request_tag_reg;
        view.seen_millihz   = seen_millihz_reg;
        view.seen_hz        = seen_hz_reg;
        view.seen_time      = seen_time_reg;
        view.thermal_on     = thermal_on_reg;
        view.battery_low    = battery_low_reg;
        view.guard_ok       = guard_ok_reg;
        view.rate_policy    = rate_policy_reg;
        view.temporal_mode  = temporal_mode_reg;
        view.adaptive_guard = adaptive_guard_reg;
    end

    `RRFP_ASSERT_NXT(a_cfg_clears_req, clk, rst_n, cfg_we && cfg_index != 2'd3, !request_flag_reg && request_tag_reg == '0)
    `RRFP_ASSERT_IMP(a_on_has_tag, clk, rst_n, surface_on_reg, surface_tag_reg != '0)
    `RRFP_ASSERT_IMP(a_seen_pair, clk, rst_n, seen_time_reg == '0, seen_millihz_reg == '0 && seen_hz_reg == '0)

endmodule

// ----- rtl/core/rrfp_eval.sv -----
// Status evaluation for a query: freshness, fallback priority chain, effective rate.
// Depends on rrfp_pkg.
`timescale 1ns / 1ps

module rrfp_eval
(
    input  logic [rrfp_pkg::TIME_BITS-1:0] now_ns,
    input  rrfp_pkg::view_t                view,
    output rrfp_pkg::result_t              result
);

    logic [rrfp_pkg::TIME_BITS:0]          age;
    logic                                  fresh;
    logic                                  req_ok;
    logic                                  guard_on;
    logic [rrfp_pkg::TARGET_BITS-1:0]      target;
    logic [rrfp_pkg::HZ_BITS-1:0]          obs_hz;
    logic [rrfp_pkg::MILLIHZ_BITS-1:0]     win_lo;
    logic [rrfp_pkg::MILLIHZ_BITS-1:0]     win_hi;
    logic                                  out_of_win;
    logic                                  motion_win;
    rrfp_pkg::fb_code_t                    code;

    // Top bit of age is the borrow: set when the query predates the observation.
    assign age   = {1'b0, now_ns} - {1'b0, view.seen_time};
    assign fresh = view.surface_on && (view.seen_time != '0) && !age[rrfp_pkg::TIME_BITS]
                && (age[rrfp_pkg::TIME_BITS-1:0] <= rrfp_pkg::TTL_NS);

    assign req_ok   = view.request_flag && (view.request_tag == view.surface_tag);
    assign guard_on = view.adaptive_guard;
    assign target   = rrfp_pkg::policy_hz(view.rate_policy);

    always_comb
    begin
        if (!fresh)
            obs_hz = rrfp_pkg::FALLBACK_HZ;
        else if (view.seen_hz == '0)
            obs_hz = rrfp_pkg::HZ_BITS'(1);
        else
            obs_hz = view.seen_hz;
    end

    always_comb
    begin
        unique case (view.rate_policy)
            rrfp_pkg::POLICY_60HZ:
            begin
                win_lo = rrfp_pkg::WIN60_LO;
                win_hi = rrfp_pkg::WIN60_HI;
            end
            rrfp_pkg::POLICY_90HZ:
            begin
                win_lo = rrfp_pkg::WIN90_LO;
                win_hi = rrfp_pkg::WIN90_HI;
            end
            default:
            begin
                win_lo = rrfp_pkg::WIN120_LO;
                win_hi = rrfp_pkg::WIN120_HI;
            end
        endcase
    end

    assign out_of_win = (view.seen_millihz < win_lo) || (view.seen_millihz > win_hi);
    assign motion_win = (view.seen_millihz >= rrfp_pkg::WIN120_LO)
                     && (view.seen_millihz <= rrfp_pkg::WIN120_HI);

    always_comb
    begin
        if (!view.surface_on)
            code = rrfp_pkg::FB_NO_SURFACE;
        else if (guard_on && !view.guard_ok)
            code = rrfp_pkg::FB_GUARD_INVAL;
        else if (guard_on && view.thermal_on)
            code = rrfp_pkg::FB_THERMAL;
        else if (guard_on && view.battery_low)
            code = rrfp_pkg::FB_BATTERY;
        else if (!req_ok)
            code = rrfp_pkg::FB_NOT_APPLIED;
        else if (!fresh)
            code = rrfp_pkg::FB_STALE;
        else if (target != '0 && out_of_win)
            code = rrfp_pkg::FB_REJECTED;
        else
            code = rrfp_pkg::FB_NONE;
    end

    always_comb
    begin
        result.ready_res           = view.surface_on;
        result.request_ok          = req_ok;
        result.current_generation  = view.surface_tag;
        result.accepted_generation = view.request_tag;
        result.target_hz           = target;
        result.last_millihz        = view.seen_millihz;
        result.last_seen_ns        = view.seen_time;
        result.fresh               = fresh;
        result.fallback_code       = code;
        if (code == rrfp_pkg::FB_NONE || code == rrfp_pkg::FB_REJECTED)
            result.effective_hz = obs_hz;
        else
            result.effective_hz = rrfp_pkg::FALLBACK_HZ;
        result.motion_ok = (code == rrfp_pkg::FB_NONE)
                        && (view.temporal_mode == rrfp_pkg::MODE_MOTION)
                        && (obs_hz == rrfp_pkg::MOTION_HZ) && motion_win;
    end

endmodule
